[hdl/gpcq_pkg.sv]
package gpcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int CPU_COUNT_DEF   = 8;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_HIGH = CFG_IDX_W'(1);

    localparam logic [1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [1:0] KIND_TICK    = 2'd1;
    localparam logic [1:0] KIND_DRAIN   = 2'd2;

    localparam logic [3:0] ST_QUEUED    = 4'd0;
    localparam logic [3:0] ST_NULL      = 4'd1;
    localparam logic [3:0] ST_BAD_CPU   = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_RECLAIMED = 4'd4;
    localparam logic [3:0] ST_NONE      = 4'd5;
    localparam logic [3:0] ST_TICKED    = 4'd6;
    localparam logic [3:0] ST_WILD      = 4'd7;
    localparam logic [3:0] ST_HALTED    = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cpu;
        logic [63:0] callback;
        logic [63:0] argument;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] out_callback;
        logic [63:0] out_argument;
        logic [63:0] out_enqueue_tick;
        logic        last;
        logic [63:0] queued_total;
        logic [63:0] completed_total;
        logic [63:0] dropped_total;
    } t_out;

    // One ring slot as it sits in the slot RAM.
    typedef struct packed {
        logic [63:0] callback;
        logic [63:0] argument;
        logic [63:0] tick;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_LAST
    } t_state;

endpackage

[hdl/gpcq_ram.sv]
module gpcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/grace_period_callback_queues_unit.sv]
// Channel    Direction  Handshake                     Payload
// command    in         i_start, o_busy               i_in  (gpcq_pkg::t_in)
// result     out        o_res_valid (one-cycle strobe) o_res (gpcq_pkg::t_out)
// config     in         i_cfg_valid, o_cfg_ready      i_cfg_index, i_cfg_data
//
// Cycles: enqueue, tick, rejects, halted replies and drains of an empty ring are
// accepted while idle, keep o_busy low and give their result in the next cycle.
// A drain of a non-empty ring reads one slot per cycle (single read port, registered
// read data) and holds o_busy until it returns to idle; a wild entry behind reclaimed
// ones is reported from S_LAST, and a wild oldest entry straight from S_WALK.
// Reset: synchronous, active low; clears ring pointers, counts, tick and halt.
// The slot RAM needs no clearing pass. The receiver cannot stall results.
module grace_period_callback_queues_unit #(
    parameter int QUEUE_DEPTH = gpcq_pkg::QUEUE_DEPTH_DEF,
    parameter int CPU_COUNT   = gpcq_pkg::CPU_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  gpcq_pkg::t_in                 i_in,
    output logic                          o_res_valid,
    output gpcq_pkg::t_out                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gpcq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int SLOTS  = CPU_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int SLOT_W = $bits(gpcq_pkg::t_slot);

    // Flat slot address of ring entry p of CPU c.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [CPU_W-1:0] c,
                                                    input logic [PTR_W-1:0] p);
        logic [ADDR_W:0] wide;
        wide = (ADDR_W+1)'(c) * (ADDR_W+1)'(QUEUE_DEPTH) + (ADDR_W+1)'(p);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Control state
    gpcq_pkg::t_state r_state, n_state;
    logic [PTR_W-1:0] r_head  [CPU_COUNT];
    logic [PTR_W-1:0] n_head  [CPU_COUNT];
    logic [PTR_W-1:0] r_tail  [CPU_COUNT];
    logic [PTR_W-1:0] n_tail  [CPU_COUNT];
    logic [CNT_W-1:0] r_count [CPU_COUNT];
    logic [CNT_W-1:0] n_count [CPU_COUNT];
    logic [63:0]      r_grace, n_grace;
    logic [63:0]      r_queued, n_queued;
    logic [63:0]      r_completed, n_completed;
    logic [63:0]      r_dropped, n_dropped;
    logic             r_halted, n_halted;
    logic             r_have_pend, n_have_pend;
    logic             r_res_valid, n_res_valid;
    logic [63:0]      r_text_low, r_text_high;

    // Payload state
    gpcq_pkg::t_out   r_res, n_res;
    gpcq_pkg::t_slot  r_pend, n_pend;
    logic             r_pend_fault, n_pend_fault;
    logic [CPU_W-1:0] r_cpu, n_cpu;

    // Slot RAM port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    gpcq_pkg::t_slot   mem_wdata;
    logic [SLOT_W-1:0] mem_rdata;
    gpcq_pkg::t_slot   rd;

    logic              accept;
    logic              in_cpu_ok;
    logic [CPU_W-1:0]  in_idx;
    logic              rd_ready;
    logic              rd_wild;
    logic [PTR_W-1:0]  next_tail;

    gpcq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd        = gpcq_pkg::t_slot'(mem_rdata);
    assign accept    = i_start && (r_state == gpcq_pkg::S_IDLE);
    assign in_cpu_ok = (i_in.cpu < 8'(CPU_COUNT));
    assign in_idx    = i_in.cpu[CPU_W-1:0];
    // An entry is ready once the grace tick has moved past its enqueue tick.
    assign rd_ready  = (r_grace > rd.tick);
    assign rd_wild   = (rd.callback < r_text_low) || (rd.callback >= r_text_high);
    assign next_tail = ptr_inc(r_tail[r_cpu]);

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_grace      = r_grace;
        n_queued     = r_queued;
        n_completed  = r_completed;
        n_dropped    = r_dropped;
        n_halted     = r_halted;
        n_have_pend  = r_have_pend;
        n_pend       = r_pend;
        n_pend_fault = r_pend_fault;
        n_cpu        = r_cpu;
        n_res_valid  = 1'b0;
        n_res        = '0;
        n_res.last   = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = slot_addr(in_idx, r_head[in_idx]);
        mem_wdata    = '{callback: i_in.callback, argument: i_in.argument, tick: r_grace};
        mem_raddr    = slot_addr(r_cpu, next_tail);

        case (r_state)
            gpcq_pkg::S_IDLE: begin
                if (accept) begin
                    if (r_halted) begin
                        n_res_valid = 1'b1;
                        n_res.status = gpcq_pkg::ST_HALTED;
                    end else begin
                        case (i_in.kind)
                            gpcq_pkg::KIND_ENQUEUE: begin
                                n_res_valid = 1'b1;
                                if (i_in.callback == '0) begin
                                    n_res.status = gpcq_pkg::ST_NULL;
                                end else if (!in_cpu_ok) begin
                                    if (r_dropped != '1) n_dropped = r_dropped + 64'd1;
                                    n_res.status = gpcq_pkg::ST_BAD_CPU;
                                end else if (r_count[in_idx] == CNT_W'(QUEUE_DEPTH)) begin
                                    if (r_dropped != '1) n_dropped = r_dropped + 64'd1;
                                    n_res.status = gpcq_pkg::ST_FULL;
                                end else begin
                                    // Store at head, advance head, bump fill.
                                    mem_we                 = 1'b1;
                                    n_head[in_idx]         = ptr_inc(r_head[in_idx]);
                                    n_count[in_idx]        = r_count[in_idx] + CNT_W'(1);
                                    n_queued               = r_queued + 64'd1;
                                    n_res.status           = gpcq_pkg::ST_QUEUED;
                                    n_res.out_callback     = i_in.callback;
                                    n_res.out_argument     = i_in.argument;
                                    n_res.out_enqueue_tick = r_grace;
                                end
                            end
                            gpcq_pkg::KIND_TICK: begin
                                n_res_valid  = 1'b1;
                                n_grace      = r_grace + 64'd1;
                                n_res.status = gpcq_pkg::ST_TICKED;
                            end
                            gpcq_pkg::KIND_DRAIN: begin
                                if (!in_cpu_ok) begin
                                    n_res_valid  = 1'b1;
                                    n_res.status = gpcq_pkg::ST_BAD_CPU;
                                end else if (r_count[in_idx] == '0) begin
                                    n_res_valid  = 1'b1;
                                    n_res.status = gpcq_pkg::ST_NONE;
                                end else begin
                                    // Fetch the oldest entry and start the walk.
                                    mem_raddr   = slot_addr(in_idx, r_tail[in_idx]);
                                    n_cpu       = in_idx;
                                    n_have_pend = 1'b0;
                                    n_state     = gpcq_pkg::S_WALK;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            gpcq_pkg::S_WALK: begin
                // The held entry goes out once we know whether another follows it.
                if (r_have_pend) begin
                    n_res_valid            = 1'b1;
                    n_res.status           = gpcq_pkg::ST_RECLAIMED;
                    n_res.out_callback     = r_pend.callback;
                    n_res.out_argument     = r_pend.argument;
                    n_res.out_enqueue_tick = r_pend.tick;
                    n_res.last             = !rd_ready;
                    n_completed            = r_completed + 64'd1;
                end
                if (!rd_ready) begin
                    if (!r_have_pend) begin
                        n_res_valid  = 1'b1;
                        n_res.status = gpcq_pkg::ST_NONE;
                    end
                    n_have_pend = 1'b0;
                    n_state     = gpcq_pkg::S_IDLE;
                end else begin
                    n_tail[r_cpu]  = next_tail;
                    n_count[r_cpu] = r_count[r_cpu] - CNT_W'(1);
                    if (rd_wild && !r_have_pend) begin
                        // Fault with nothing ahead of it: report and halt now.
                        n_res_valid            = 1'b1;
                        n_res.status           = gpcq_pkg::ST_WILD;
                        n_res.out_callback     = rd.callback;
                        n_res.out_argument     = rd.argument;
                        n_res.out_enqueue_tick = rd.tick;
                        n_halted               = 1'b1;
                        n_state                = gpcq_pkg::S_IDLE;
                    end else begin
                        n_pend       = rd;
                        n_pend_fault = rd_wild;
                        n_have_pend  = 1'b1;
                        if (rd_wild || (r_count[r_cpu] == CNT_W'(1))) begin
                            n_state = gpcq_pkg::S_LAST;
                        end
                    end
                end
            end

            gpcq_pkg::S_LAST: begin
                n_res_valid            = 1'b1;
                n_res.out_callback     = r_pend.callback;
                n_res.out_argument     = r_pend.argument;
                n_res.out_enqueue_tick = r_pend.tick;
                if (r_pend_fault) begin
                    n_res.status = gpcq_pkg::ST_WILD;
                    n_halted     = 1'b1;
                end else begin
                    n_res.status = gpcq_pkg::ST_RECLAIMED;
                    n_completed  = r_completed + 64'd1;
                end
                n_have_pend = 1'b0;
                n_state     = gpcq_pkg::S_IDLE;
            end

            default: begin
                n_state = gpcq_pkg::S_IDLE;
            end
        endcase

        // Totals in a result reflect that result's own update.
        n_res.queued_total    = n_queued;
        n_res.completed_total = n_completed;
        n_res.dropped_total   = n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gpcq_pkg::S_IDLE;
            r_head      <= '{default: '0};
            r_tail      <= '{default: '0};
            r_count     <= '{default: '0};
            r_grace     <= '0;
            r_queued    <= '0;
            r_completed <= '0;
            r_dropped   <= '0;
            r_halted    <= 1'b0;
            r_have_pend <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_grace     <= n_grace;
            r_queued    <= n_queued;
            r_completed <= n_completed;
            r_dropped   <= n_dropped;
            r_halted    <= n_halted;
            r_have_pend <= n_have_pend;
            r_res_valid <= n_res_valid;
        end
    end

    // Configuration registers; writes to unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_low  <= '0;
            r_text_high <= '1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == gpcq_pkg::CFG_TEXT_LOW) begin
                r_text_low <= i_cfg_data;
            end
            if (i_cfg_index == gpcq_pkg::CFG_TEXT_HIGH) begin
                r_text_high <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res        <= n_res;
        r_pend       <= n_pend;
        r_pend_fault <= n_pend_fault;
        r_cpu        <= n_cpu;
    end

    assign o_busy      = (r_state != gpcq_pkg::S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

[verif/grace_period_callback_queues_unit_tb.sv]
`timescale 1ns / 100ps

module grace_period_callback_queues_unit_tb;

    import gpcq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam int NCPU   = CPU_COUNT_DEF;

    // Kind 3 has no name in the package; the block ignores it unless halted.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    // Register index past the end of the map; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED = CFG_IDX_W'(8'hA5);

    localparam logic [63:0] ALL_ONES = '1;
    localparam t_slot       NO_SLOT  = '0;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    t_in                  i_in;
    logic                 o_res_valid;
    t_out                 o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    grace_period_callback_queues_unit #(
        .QUEUE_DEPTH (QDEPTH),
        .CPU_COUNT   (NCPU)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: rings, tick, counters, halt flag, window.
    // Every accepted command is replayed here to produce its replies.
    // ------------------------------------------------------------------
    t_slot       ring_slot [NCPU][QDEPTH];
    int          ring_rd   [NCPU];
    int          ring_wr   [NCPU];
    int          ring_fill [NCPU];
    logic [63:0] grace_now     = '0;
    logic [63:0] queued_cnt    = '0;
    logic [63:0] reclaimed_cnt = '0;
    logic [63:0] dropped_cnt   = '0;
    bit          halted        = 1'b0;
    logic [63:0] win_low       = '0;
    logic [63:0] win_high      = '1;

    // Replies still owed by the block, oldest first.
    t_out        due_results [$];

    int          issued       = 0;
    int          results_seen = 0;
    int          errors       = 0;
    t_out        want;

    // Directed script: a row carries a hand-typed reply only where it is obvious.
    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out res;
    } script_row_t;

    script_row_t script [$];

    // ------------------------------------------------------------------
    // Clock: 20 ns period.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Draw a callback address in [lo, hi]; a zero span means the whole space.
    function automatic logic [63:0] pick_cb(logic [63:0] lo, logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo + 64'd1;
        if (span == '0) return rand64();
        return lo + (rand64() % span);
    endfunction

    function automatic t_in mk_cmd(logic [1:0] kind, logic [7:0] cpu,
                                   logic [63:0] cb, logic [63:0] arg);
        t_in c;
        c.kind     = kind;
        c.cpu      = cpu;
        c.callback = cb;
        c.argument = arg;
        return c;
    endfunction

    function automatic t_out mk_res(logic [3:0] status, logic [63:0] cb,
                                    logic [63:0] arg, logic [63:0] tick,
                                    logic [63:0] q, logic [63:0] c,
                                    logic [63:0] d);
        t_out r;
        r.status           = status;
        r.out_callback     = cb;
        r.out_argument     = arg;
        r.out_enqueue_tick = tick;
        r.last             = 1'b1;
        r.queued_total     = q;
        r.completed_total  = c;
        r.dropped_total    = d;
        return r;
    endfunction

    // Queue one reply carrying the counters as they stand after its own update.
    task automatic post_reply(input logic [3:0] status, input t_slot s,
                              input logic last);
        due_results.push_back(mk_res(status, s.callback, s.argument, s.tick,
                                     queued_cnt, reclaimed_cnt, dropped_cnt));
        due_results[due_results.size()-1].last = last;
    endtask

    function automatic void bump_dropped();
        // Hold at all ones.
        if (dropped_cnt != ALL_ONES) dropped_cnt++;
    endfunction

    // Work out the replies of one accepted command and advance the shadow state.
    task automatic predict_replies(input t_in cmd);
        int    c;
        int    popped;
        bit    stop;
        bit    wild;
        t_slot s;
        c = int'(cmd.cpu);
        if (halted) begin
            // Halted: one halted reply for any kind, state frozen.
            post_reply(ST_HALTED, NO_SLOT, 1'b1);
            return;
        end
        case (cmd.kind)
            KIND_ENQUEUE: begin
                // Null check wins over the cpu check.
                if (cmd.callback == '0) begin
                    post_reply(ST_NULL, NO_SLOT, 1'b1);
                end else if (c >= NCPU) begin
                    bump_dropped();
                    post_reply(ST_BAD_CPU, NO_SLOT, 1'b1);
                end else if (ring_fill[c] >= QDEPTH) begin
                    bump_dropped();
                    post_reply(ST_FULL, NO_SLOT, 1'b1);
                end else begin
                    s.callback = cmd.callback;
                    s.argument = cmd.argument;
                    s.tick     = grace_now;
                    ring_slot[c][ring_wr[c]] = s;
                    ring_wr[c] = (ring_wr[c] + 1) % QDEPTH;
                    ring_fill[c]++;
                    queued_cnt++;
                    post_reply(ST_QUEUED, s, 1'b1);
                end
            end
            KIND_TICK: begin
                grace_now++;
                post_reply(ST_TICKED, NO_SLOT, 1'b1);
            end
            KIND_DRAIN: begin
                if (c >= NCPU) begin
                    post_reply(ST_BAD_CPU, NO_SLOT, 1'b1);
                    return;
                end
                popped = 0;
                stop   = 1'b0;
                wild   = 1'b0;
                // Pop from the oldest entry while it predates the current tick.
                while (!stop && ring_fill[c] > 0 && popped < QDEPTH) begin
                    s = ring_slot[c][ring_rd[c]];
                    if (!(grace_now > s.tick)) begin
                        stop = 1'b1;
                    end else begin
                        ring_rd[c] = (ring_rd[c] + 1) % QDEPTH;
                        ring_fill[c]--;
                        if (s.callback < win_low || s.callback >= win_high) begin
                            // Wild address: report it, end the drain, halt.
                            halted = 1'b1;
                            wild   = 1'b1;
                            stop   = 1'b1;
                            post_reply(ST_WILD, s, 1'b1);
                        end else begin
                            reclaimed_cnt++;
                            post_reply(ST_RECLAIMED, s, 1'b0);
                            popped++;
                        end
                    end
                end
                if (!wild) begin
                    if (popped == 0) post_reply(ST_NONE, NO_SLOT, 1'b1);
                    else due_results[due_results.size()-1].last = 1'b1;
                end
            end
            default: begin
                // Unused kind: no reply, no state change.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------

    // Hold start and payload until the block takes the transaction, then predict.
    task automatic issue(input t_in cmd);
        i_start <= 1'b1;
        i_in    <= cmd;
        do @(posedge i_clk); while (o_busy);
        predict_replies(cmd);
        issued++;
    endtask

    // Mostly short gaps, a few long ones; every third run of 32 commands
    // goes back to back.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((issued >> 5) % 3) == 2) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic pace();
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_start <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drop start, wait for every owed reply, then let a full drain walk pass.
    task automatic settle();
        i_start <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (QDEPTH + 8) @(posedge i_clk);
    endtask

    // Program the address window; optionally hit an unmapped index as well.
    task automatic set_window(input logic [63:0] lo, input logic [63:0] hi,
                              input bit stray);
        logic [CFG_IDX_W-1:0] idx [$];
        logic [63:0]          val [$];
        idx.push_back(CFG_TEXT_LOW);
        val.push_back(lo);
        idx.push_back(CFG_TEXT_HIGH);
        val.push_back(hi);
        if (stray) begin
            idx.push_back(CFG_IDX_UNMAPPED);
            val.push_back(rand64());
        end
        for (int k = 0; k < idx.size(); k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            if (idx[k] == CFG_TEXT_LOW) win_low = val[k];
            else if (idx[k] == CFG_TEXT_HIGH) win_high = val[k];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Advance the tick once, then drain every CPU so all rings end up empty.
    task automatic flush_rings();
        issue(mk_cmd(KIND_TICK, '0, '0, '0));
        pace();
        for (int c = 0; c < NCPU; c++) begin
            issue(mk_cmd(KIND_DRAIN, 8'(c), rand64(), rand64()));
            pace();
        end
    endtask

    // Random traffic: mostly enqueues with callbacks in [lo, hi], ticks and drains, with
    // rejects, nulls and unused kinds mixed in. Unused kinds do not count.
    task automatic run_phase(input int n, input logic [63:0] lo,
                             input logic [63:0] hi, input bit drains_ok);
        int  done_items;
        int  pick;
        t_in cmd;
        done_items = 0;
        while (done_items < n) begin
            pick = $urandom_range(0, 99);
            cmd  = mk_cmd(KIND_ENQUEUE, 8'($urandom_range(0, NCPU - 1)),
                          pick_cb(lo, hi), rand64());
            if (pick >= 45 && pick < 60) begin
                cmd.kind = KIND_TICK;
            end else if (pick >= 60 && pick < 78) begin
                cmd.kind = drains_ok ? KIND_DRAIN : KIND_TICK;
            end else if (pick >= 78 && pick < 83) begin
                cmd.cpu = 8'($urandom_range(NCPU, 255));
            end else if (pick >= 83 && pick < 86) begin
                cmd.kind = KIND_DRAIN;
                cmd.cpu  = 8'($urandom_range(NCPU, 255));
            end else if (pick >= 86 && pick < 90) begin
                cmd.callback = '0;
                cmd.cpu      = 8'($urandom_range(0, 255));
            end else if (pick >= 90 && pick < 93) begin
                cmd.kind     = KIND_UNUSED;
                cmd.cpu      = 8'($urandom);
                cmd.callback = rand64();
            end else if (pick >= 93) begin
                cmd.cpu = 8'($urandom_range(0, 255));
            end
            issue(cmd);
            pace();
            if (cmd.kind != KIND_UNUSED) done_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Reply checker: the receiver cannot stall, so sample every strobe.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] want_v,
                                        logic [63:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %h, got %h", name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            results_seen++;
            if (due_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d", o_res.status);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("status",           64'(want.status), 64'(o_res.status));
                check_field("out_callback",     want.out_callback, o_res.out_callback);
                check_field("out_argument",     want.out_argument, o_res.out_argument);
                check_field("out_enqueue_tick", want.out_enqueue_tick,
                            o_res.out_enqueue_tick);
                check_field("last",             64'(want.last), 64'(o_res.last));
                check_field("queued_total",     want.queued_total, o_res.queued_total);
                check_field("completed_total",  want.completed_total,
                            o_res.completed_total);
                check_field("dropped_total",    want.dropped_total, o_res.dropped_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin
        int fill_cpu;
        int fault_cpu;

        // Drive every input to a known value and hold reset.
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset window [0, all ones).
        script.push_back('{mk_cmd(KIND_TICK, 8'd0, '0, '0), 1'b1,
                           mk_res(ST_TICKED, '0, '0, '0, '0, '0, '0)});
        script.push_back('{mk_cmd(KIND_DRAIN, 8'd0, '0, '0), 1'b1,
                           mk_res(ST_NONE, '0, '0, '0, '0, '0, '0)});
        // Null wins even with a bad cpu.
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'hFF, '0, ALL_ONES), 1'b1,
                           mk_res(ST_NULL, '0, '0, '0, '0, '0, '0)});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'(NCPU), 64'd1, '0), 1'b1,
                           mk_res(ST_BAD_CPU, '0, '0, '0, '0, '0, 64'd1)});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'hFF, ALL_ONES, ALL_ONES), 1'b1,
                           mk_res(ST_BAD_CPU, '0, '0, '0, '0, '0, 64'd2)});
        // Bad cpu on a drain leaves the drop count alone.
        script.push_back('{mk_cmd(KIND_DRAIN, 8'hFF, '0, '0), 1'b1,
                           mk_res(ST_BAD_CPU, '0, '0, '0, '0, '0, 64'd2)});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'd0, 64'd1, '0), 1'b1,
                           mk_res(ST_QUEUED, 64'd1, '0, 64'd1, 64'd1, '0, 64'd2)});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'd0, ALL_ONES - 64'd1, ALL_ONES), 1'b1,
                           mk_res(ST_QUEUED, ALL_ONES - 64'd1, ALL_ONES, 64'd1,
                                  64'd2, '0, 64'd2)});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'(NCPU - 1), 64'h5555_5555_5555_5555,
                                  64'hAAAA_AAAA_AAAA_AAAA), 1'b0, '0});
        // Same tick as the entries: nothing is old enough yet.
        script.push_back('{mk_cmd(KIND_DRAIN, 8'd0, '0, '0), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_UNUSED, 8'd0, ALL_ONES, ALL_ONES), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_TICK, 8'hFF, ALL_ONES, ALL_ONES), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_DRAIN, 8'd0, '0, '0), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_DRAIN, 8'(NCPU - 1), '0, '0), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_DRAIN, 8'(NCPU - 1), '0, '0), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_ENQUEUE, 8'd3, ALL_ONES - 64'd1, 64'd1), 1'b0, '0});
        script.push_back('{mk_cmd(KIND_DRAIN, 8'd3, '0, '0), 1'b0, '0});

        foreach (script[k]) begin
            issue(script[k].cmd);
            // Overwrite the prediction with the hand-typed reply where given.
            if (script[k].typed) due_results[due_results.size()-1] = script[k].res;
            pace();
        end

        // Fill one ring to the brim, overflow it, then drain it in one go.
        fill_cpu = $urandom_range(0, NCPU - 1);
        while (ring_fill[fill_cpu] < QDEPTH) begin
            issue(mk_cmd(KIND_ENQUEUE, 8'(fill_cpu), pick_cb(64'd1, ALL_ONES - 64'd1),
                         rand64()));
            pace();
        end
        repeat (2) begin
            issue(mk_cmd(KIND_ENQUEUE, 8'(fill_cpu), rand64() | 64'd1, rand64()));
            pace();
        end
        issue(mk_cmd(KIND_TICK, '0, '0, '0));
        pace();
        issue(mk_cmd(KIND_DRAIN, 8'(fill_cpu), '0, '0));
        pace();

        // Reset window, full address space.
        run_phase(70, 64'd1, ALL_ONES - 64'd1, 1'b1);
        flush_rings();

        // Narrow window.
        settle();
        set_window(64'h1000, 64'h2000, 1'b1);
        run_phase(70, 64'h1000, 64'h1FFF, 1'b1);
        flush_rings();

        // Upper half of the address space.
        settle();
        set_window(64'h8000_0000_0000_0000, ALL_ONES, 1'b0);
        run_phase(70, 64'h8000_0000_0000_0000, ALL_ONES - 64'd1, 1'b1);
        flush_rings();

        // Single valid address.
        settle();
        set_window(64'd1, 64'd2, 1'b0);
        run_phase(70, 64'd1, 64'd1, 1'b1);
        flush_rings();

        // Empty window: enqueues and ticks, drains only with a bad cpu, since any pop would fault.
        settle();
        set_window(ALL_ONES, '0, 1'b1);
        run_phase(70, 64'd1, ALL_ONES - 64'd1, 1'b0);

        // Back to the full window; the backlog from the empty window drains clean.
        settle();
        set_window('0, ALL_ONES, 1'b1);
        run_phase(70, 64'd1, ALL_ONES - 64'd1, 1'b1);
        flush_rings();

        // Wild fault: good entry, then all ones (the exclusive upper bound),
        // then one more that stays behind in the ring.
        fault_cpu = $urandom_range(0, NCPU - 1);
        issue(mk_cmd(KIND_ENQUEUE, 8'(fault_cpu), 64'h0000_0000_0040_1000, rand64()));
        pace();
        issue(mk_cmd(KIND_ENQUEUE, 8'(fault_cpu), ALL_ONES, rand64()));
        pace();
        issue(mk_cmd(KIND_ENQUEUE, 8'(fault_cpu), 64'h0000_0000_0040_2000, rand64()));
        pace();
        issue(mk_cmd(KIND_TICK, '0, '0, '0));
        pace();
        issue(mk_cmd(KIND_DRAIN, 8'(fault_cpu), '0, '0));
        pace();

        // Halted: every kind, the unused one too, answers with a halted reply.
        issue(mk_cmd(KIND_ENQUEUE, 8'(fault_cpu), 64'd1, rand64()));
        pace();
        issue(mk_cmd(KIND_TICK, '0, '0, '0));
        pace();
        issue(mk_cmd(KIND_DRAIN, 8'(fault_cpu), '0, '0));
        pace();
        issue(mk_cmd(KIND_UNUSED, 8'hFF, rand64(), rand64()));
        pace();

        // Register writes still go through while halted.
        settle();
        set_window(64'd1, ALL_ONES, 1'b1);
        run_phase(8, 64'd1, ALL_ONES - 64'd1, 1'b1);

        // Wait out the remaining replies, bounded.
        i_start <= 1'b0;
        for (int w = 0; w < 20000 && due_results.size() != 0; w++) @(posedge i_clk);
        repeat (QDEPTH + 8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            errors++;
        end

        $display("Sent %0d commands across six address windows; checked %0d results.",
                 issued, results_seen);
        $display("Reclaimed %0d callbacks, dropped %0d enqueues, then faulted and halted.",
                 reclaimed_cnt, dropped_cnt);
        if (errors == 0) begin
            $display("** grace_period_callback_queues_unit: PASSED **");
        end else begin
            $display("** grace_period_callback_queues_unit: FAILED **");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("** grace_period_callback_queues_unit: FAILED **");
        $finish;
    end

endmodule
